// ===== rtl/tmtw_pkg.sv =====
// ============================================================================
// tmtw_pkg
// Shared types and constants for the text-mode terminal writer: field widths,
// operation codes and the request passed to the address unit.
// ============================================================================
package tmtw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int ENTRY_W    = 16;
    localparam int ROW_CALC_W = 6;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ADDR_HOLD = 2'd0,
        ADDR_LOAD = 2'd1,
        ADDR_INC  = 2'd2,
        ADDR_ZERO = 2'd3
    } addr_op_t;

    typedef struct packed {
        addr_op_t              op;
        logic [ROW_CALC_W-1:0] row;
        logic [COL_W-1:0]      col;
    } addr_req_t;

endpackage

// ===== rtl/tmtw_cell_ram.sv =====
// ============================================================================
// tmtw_cell_ram
// Screen cell store: one write port and one read port with registered data.
// ============================================================================
module tmtw_cell_ram #(
    parameter int DEPTH = tmtw_pkg::DEF_ROWS * tmtw_pkg::DEF_COLUMNS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [tmtw_pkg::ENTRY_W-1:0] wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [tmtw_pkg::ENTRY_W-1:0] rdata
);

    logic [tmtw_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [tmtw_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tmtw_addr_unit.sv =====
// ============================================================================
// tmtw_addr_unit
// Shared cell address register: loads row * COLUMNS + column for single cell
// accesses and steps through the store for scroll and clear sweeps.
// ============================================================================
module tmtw_addr_unit #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int AW      = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tmtw_pkg::addr_req_t req,
    output logic [AW-1:0]       addr
);

    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;
    logic [31:0]   prod;

    always_comb
    begin
        prod = 32'(req.row) * 32'(COLUMNS) + 32'(req.col);
        unique case (req.op)
            tmtw_pkg::ADDR_HOLD: addr_next = addr_reg;
            tmtw_pkg::ADDR_LOAD: addr_next = prod[AW-1:0];
            tmtw_pkg::ADDR_INC:  addr_next = addr_reg + AW'(1);
            tmtw_pkg::ADDR_ZERO: addr_next = '0;
            default:             addr_next = addr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
        end
    end

    assign addr = addr_reg;

endmodule

// ===== rtl/text_mode_terminal_writer.sv =====
// ============================================================================
// text_mode_terminal_writer
// Text-mode terminal: a ROWS x COLUMNS cell store with a cursor, driven by
// put-char, write-cell, read-cell and clear requests.
// ============================================================================
// An accepted request passes S_EXEC, then S_READ for a cell read, then S_DONE,
// where its result is registered; one request is in work at a time and the
// next is taken once its result is registered, which a receiver stall holds off.
// A scroll adds S_SCROLL_PRE and a sweep of every cell, and a clear a sweep of
// every cell, both stepped through the store by the shared address unit.
// After reset a pass over every cell blanks the store; cfg writes any time.
// ============================================================================
module text_mode_terminal_writer #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tmtw_pkg::COLOR_W-1:0]   cfg_wdata,   // text_color
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // char_code[7:0], cell_color[15:8], col[22:16], row[27:23], zero fill
    input  logic [tmtw_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [tmtw_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_entry[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28],
    // zero fill
    output logic [tmtw_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int N  = ROWS * COLUMNS;
    localparam int AW = $clog2(N);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL_PRE,
        S_SCROLL,
        S_FILL,
        S_DONE
    } state_t;

    state_t                         state_reg, state_next;
    tmtw_pkg::func_t                func_reg, func_next;
    logic [tmtw_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic [tmtw_pkg::COLOR_W-1:0]   attr_reg, attr_next;
    logic                           in_range_reg, in_range_next;
    logic [RW-1:0]                  cur_row_reg, cur_row_next;
    logic [CW-1:0]                  cur_col_reg, cur_col_next;
    logic                           scrolled_reg, scrolled_next;
    logic [tmtw_pkg::ENTRY_W-1:0]   entry_reg, entry_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [tmtw_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [tmtw_pkg::COLOR_W-1:0]   text_color_reg, text_color_next;

    tmtw_pkg::addr_req_t            addr_req;
    logic [AW-1:0]                  addr;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [tmtw_pkg::ENTRY_W-1:0]   ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [tmtw_pkg::ENTRY_W-1:0]   ram_rdata;

    logic [tmtw_pkg::CHAR_W-1:0]    in_char;
    logic [tmtw_pkg::COLOR_W-1:0]   in_attr;
    logic [tmtw_pkg::COL_W-1:0]     in_col;
    logic [tmtw_pkg::ROW_W-1:0]     in_row;
    tmtw_pkg::func_t                in_func;
    logic                           s_accept;
    logic                           addr_last;
    logic                           row_last;
    logic [CW:0]                    col_inc;
    logic                           col_wrap;
    logic                           need_nl;
    logic [AW:0]                    scroll_raddr;
    logic [tmtw_pkg::ENTRY_W-1:0]   blank_entry;

    assign in_char  = s_tdata[7:0];
    assign in_attr  = s_tdata[15:8];
    assign in_col   = s_tdata[22:16];
    assign in_row   = s_tdata[27:23];
    assign in_func  = tmtw_pkg::func_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign addr_last    = (addr == AW'(N - 1));
    assign row_last     = (cur_row_reg == RW'(ROWS - 1));
    assign col_inc      = {1'b0, cur_col_reg} + (CW + 1)'(1);
    assign col_wrap     = (col_inc >= (CW + 1)'(COLUMNS));
    assign need_nl      = (char_reg == tmtw_pkg::NEWLINE_CODE) || col_wrap;
    assign scroll_raddr = {1'b0, addr} + (AW + 1)'(COLUMNS + 1);
    assign blank_entry  = {text_color_reg, tmtw_pkg::SPACE_CODE};

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        char_next       = char_reg;
        attr_next       = attr_reg;
        in_range_next   = in_range_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        scrolled_next   = scrolled_reg;
        entry_next      = entry_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        text_color_next = cfg_we ? cfg_wdata : text_color_reg;

        addr_req.op  = tmtw_pkg::ADDR_HOLD;
        addr_req.row = tmtw_pkg::ROW_CALC_W'(cur_row_reg);
        addr_req.col = tmtw_pkg::COL_W'(cur_col_reg);
        ram_we    = 1'b0;
        ram_waddr = addr;
        ram_wdata = blank_entry;
        ram_re    = 1'b0;
        ram_raddr = addr;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {tmtw_pkg::RESET_COLOR, tmtw_pkg::SPACE_CODE};
                if (addr_last)
                begin
                    addr_req.op = tmtw_pkg::ADDR_ZERO;
                    state_next  = S_IDLE;
                end
                else
                begin
                    addr_req.op = tmtw_pkg::ADDR_INC;
                end
            end
            S_IDLE:
            begin
                if (s_accept)
                begin
                    func_next     = in_func;
                    char_next     = in_char;
                    attr_next     = in_attr;
                    in_range_next = (32'(in_col) < 32'(COLUMNS))
                                    && (32'(in_row) < 32'(ROWS));
                    scrolled_next = 1'b0;
                    entry_next    = '0;
                    addr_req.op   = tmtw_pkg::ADDR_LOAD;
                    if (in_func != tmtw_pkg::FUNC_PUT)
                    begin
                        addr_req.row = tmtw_pkg::ROW_CALC_W'(in_row);
                        addr_req.col = in_col;
                    end
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (func_reg)
                    tmtw_pkg::FUNC_PUT:
                    begin
                        if (char_reg != tmtw_pkg::NEWLINE_CODE)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {text_color_reg, char_reg};
                        end
                        if (need_nl)
                        begin
                            cur_col_next = '0;
                            if (row_last)
                            begin
                                scrolled_next = 1'b1;
                                addr_req.op   = tmtw_pkg::ADDR_ZERO;
                                state_next    = S_SCROLL_PRE;
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + RW'(1);
                                state_next   = S_DONE;
                            end
                        end
                        else
                        begin
                            cur_col_next = col_inc[CW-1:0];
                            state_next   = S_DONE;
                        end
                    end
                    tmtw_pkg::FUNC_WRITE:
                    begin
                        ram_we     = in_range_reg;
                        ram_wdata  = {attr_reg, char_reg};
                        state_next = S_DONE;
                    end
                    tmtw_pkg::FUNC_READ:
                    begin
                        ram_re     = in_range_reg;
                        state_next = S_READ;
                    end
                    tmtw_pkg::FUNC_CLEAR:
                    begin
                        cur_row_next = '0;
                        cur_col_next = '0;
                        addr_req.op  = tmtw_pkg::ADDR_ZERO;
                        state_next   = S_FILL;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                entry_next = in_range_reg ? ram_rdata : '0;
                state_next = S_DONE;
            end
            S_SCROLL_PRE:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(COLUMNS);
                state_next = S_SCROLL;
            end
            S_SCROLL:
            begin
                ram_we    = 1'b1;
                ram_wdata = (addr < AW'(N - COLUMNS)) ? ram_rdata : blank_entry;
                ram_re    = (scroll_raddr < (AW + 1)'(N));
                ram_raddr = scroll_raddr[AW-1:0];
                if (addr_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    addr_req.op = tmtw_pkg::ADDR_INC;
                end
            end
            S_FILL:
            begin
                ram_we = 1'b1;
                if (addr_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    addr_req.op = tmtw_pkg::ADDR_INC;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, scrolled_reg,
                                     tmtw_pkg::COL_W'(cur_col_reg),
                                     tmtw_pkg::ROW_W'(cur_row_reg),
                                     entry_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            func_reg       <= tmtw_pkg::FUNC_PUT;
            char_reg       <= '0;
            attr_reg       <= '0;
            in_range_reg   <= 1'b0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            scrolled_reg   <= 1'b0;
            entry_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            text_color_reg <= tmtw_pkg::RESET_COLOR;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            char_reg       <= char_next;
            attr_reg       <= attr_next;
            in_range_reg   <= in_range_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            scrolled_reg   <= scrolled_next;
            entry_reg      <= entry_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            text_color_reg <= text_color_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    tmtw_addr_unit #(
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_addr_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (addr_req),
        .addr  (addr)
    );

    tmtw_cell_ram #(
        .DEPTH (N),
        .AW    (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== tb/tb_text_mode_terminal_writer.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_text_mode_terminal_writer
// Self-checking testbench for the text-mode terminal writer. A shadow copy
// of the cell store, the cursor and the text colour predicts the status word
// of every accepted request; results are compared field by field in order.
// A short directed run covers reset contents, range edges, newline and clear.
// Several colour phases of random text lines, cell writes, reads and clears
// then follow, with random gaps and stalls, a stall-free phase and a long
// receiver hold-off.
// ============================================================================
module tb_text_mode_terminal_writer;
    import tmtw_pkg::*;

    localparam int COLUMNS         = DEF_COLUMNS;
    localparam int ROWS            = DEF_ROWS;
    localparam int CELLS           = COLUMNS * ROWS;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int SETTLE_CYCLES   = 20;

    typedef struct packed {
        logic [2:0]         fill;
        logic               scrolled;
        logic [COL_W-1:0]   cursor_col;
        logic [ROW_W-1:0]   cursor_row;
        logic [ENTRY_W-1:0] read_entry;
    } status_t;

    class screen_scoreboard;
        logic [ENTRY_W-1:0] shadow_cells [CELLS];
        int                 cursor_y;
        int                 cursor_x;
        logic [COLOR_W-1:0] attr_reg;
        status_t            pending_status [$];
        int                 errors;

        function new();
            cursor_y = 0;
            cursor_x = 0;
            attr_reg = RESET_COLOR;
            errors   = 0;
            foreach (shadow_cells[i])
                shadow_cells[i] = {RESET_COLOR, SPACE_CODE};
        endfunction

        function void set_color(logic [COLOR_W-1:0] color);
            attr_reg = color;
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        function logic advance_line();
            int i;
            cursor_x = 0;
            if (cursor_y + 1 < ROWS)
            begin
                cursor_y++;
                return 1'b0;
            end
            for (i = 0; i < CELLS - COLUMNS; i++)
                shadow_cells[i] = shadow_cells[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++)
                shadow_cells[i] = {attr_reg, SPACE_CODE};
            return 1'b1;
        endfunction

        function void apply_request(func_t func, logic [CHAR_W-1:0] ch,
                                    logic [COLOR_W-1:0] attr, logic [COL_W-1:0] col,
                                    logic [ROW_W-1:0] row);
            status_t status;
            logic    in_range;
            int      addr;
            status   = '0;
            in_range = (int'(col) < COLUMNS) && (int'(row) < ROWS);
            addr     = int'(row) * COLUMNS + int'(col);
            case (func)
                FUNC_PUT:
                begin
                    if (ch == NEWLINE_CODE)
                        status.scrolled = advance_line();
                    else
                    begin
                        shadow_cells[cursor_y * COLUMNS + cursor_x] = {attr_reg, ch};
                        cursor_x++;
                        if (cursor_x >= COLUMNS)
                            status.scrolled = advance_line();
                    end
                end
                FUNC_WRITE:
                begin
                    if (in_range)
                        shadow_cells[addr] = {attr, ch};
                end
                FUNC_READ:
                begin
                    if (in_range)
                        status.read_entry = shadow_cells[addr];
                end
                default:
                begin
                    foreach (shadow_cells[i])
                        shadow_cells[i] = {attr_reg, SPACE_CODE};
                    cursor_y = 0;
                    cursor_x = 0;
                end
            endcase
            status.cursor_row = ROW_W'(cursor_y);
            status.cursor_col = COL_W'(cursor_x);
            pending_status.push_back(status);
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (pending_status.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            if (got.read_entry !== want.read_entry)
            begin
                $display("%0t: read_entry expected %h actual %h",
                         $time, want.read_entry, got.read_entry);
                errors++;
            end
            if (got.cursor_row !== want.cursor_row)
            begin
                $display("%0t: cursor_row expected %0d actual %0d",
                         $time, want.cursor_row, got.cursor_row);
                errors++;
            end
            if (got.cursor_col !== want.cursor_col)
            begin
                $display("%0t: cursor_col expected %0d actual %0d",
                         $time, want.cursor_col, got.cursor_col);
                errors++;
            end
            if (got.scrolled !== want.scrolled)
            begin
                $display("%0t: scrolled expected %b actual %b",
                         $time, want.scrolled, got.scrolled);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [COLOR_W-1:0]   cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    screen_scoreboard board;
    bit               no_idle;
    bit               holdoff_req;

    text_mode_terminal_writer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("[text_mode_terminal_writer] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.apply_request(func_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
                                s_tdata[22:16], s_tdata[27:23]);
        if (rst_n && m_tvalid && m_tready)
            board.check_status(status_t'(m_tdata));
    end

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_request(func_t func, logic [CHAR_W-1:0] ch,
                                logic [COLOR_W-1:0] attr, logic [COL_W-1:0] col,
                                logic [ROW_W-1:0] row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, row, col, attr, ch};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic write_text_color(logic [COLOR_W-1:0] color);
        cfg_we    <= 1'b1;
        cfg_wdata <= color;
        @(posedge clk);
        board.set_color(color);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_group(output int count);
        int               pick;
        int               len;
        int               i;
        int               reads;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        pick = $urandom_range(0, 99);
        col  = COL_W'($urandom_range(0, 127));
        row  = ROW_W'($urandom_range(0, 31));
        if ($urandom_range(0, 9) != 0)
        begin
            col = COL_W'($urandom_range(0, COLUMNS - 1));
            row = ROW_W'($urandom_range(0, ROWS - 1));
        end
        count = 1;
        if (pick < 30)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 100)
                                              : $urandom_range(0, 30);
            for (i = 0; i < len; i++)
                send_request(FUNC_PUT, CHAR_W'($urandom_range(32, 126)), COLOR_W'($urandom),
                             COL_W'($urandom), ROW_W'($urandom));
            count = len;
            if ($urandom_range(0, 4) != 0)
            begin
                send_request(FUNC_PUT, NEWLINE_CODE, COLOR_W'($urandom),
                             COL_W'($urandom), ROW_W'($urandom));
                count++;
            end
            reads = $urandom_range(1, 4);
            for (i = 0; i < reads; i++)
            begin
                row = ROW_W'((board.cursor_y > 0) ? board.cursor_y - $urandom_range(0, 1)
                                                  : 0);
                send_request(FUNC_READ, CHAR_W'($urandom), COLOR_W'($urandom),
                             COL_W'($urandom_range(0, COLUMNS - 1)), row);
            end
            count += reads;
        end
        else if (pick < 50)
            send_request(FUNC_PUT,
                         ($urandom_range(0, 1) == 0) ? NEWLINE_CODE : CHAR_W'($urandom),
                         COLOR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
        else if (pick < 65)
            send_request(FUNC_WRITE, CHAR_W'($urandom), COLOR_W'($urandom), col, row);
        else if (pick < 97)
            send_request(FUNC_READ, CHAR_W'($urandom), COLOR_W'($urandom), col, row);
        else
            send_request(FUNC_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), col, row);
    endtask

    initial
    begin
        logic [COLOR_W-1:0] phase_colors [PHASES];
        int                 phase;
        int                 sent;
        int                 count;

        board       = new();
        no_idle     = 1'b0;
        holdoff_req = 1'b0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_PUT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_request(FUNC_READ,  8'h00, 8'h00, 7'd0,   5'd0);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd79,  5'd24);
        send_request(FUNC_READ,  8'hFF, 8'hFF, 7'd127, 5'd31);
        send_request(FUNC_WRITE, 8'hFF, 8'hFF, 7'd0,   5'd0);
        send_request(FUNC_WRITE, 8'h00, 8'h00, 7'd79,  5'd24);
        send_request(FUNC_WRITE, 8'h55, 8'hAA, 7'd80,  5'd3);
        send_request(FUNC_WRITE, 8'hAA, 8'h55, 7'd5,   5'd25);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd0,   5'd0);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd79,  5'd24);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd80,  5'd3);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd5,   5'd25);
        send_request(FUNC_PUT,   8'h41, 8'h00, 7'd0,   5'd0);
        send_request(FUNC_PUT,   8'h00, 8'hFF, 7'd127, 5'd31);
        send_request(FUNC_PUT,   8'hFF, 8'h00, 7'd0,   5'd0);
        send_request(FUNC_PUT,   NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd2,   5'd0);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd1,   5'd0);
        send_request(FUNC_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd0,   5'd0);
        send_request(FUNC_PUT,   NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
        send_request(FUNC_READ,  8'h00, 8'h00, 7'd79,  5'd24);

        phase_colors[0] = 8'h00;
        phase_colors[1] = 8'hFF;
        phase_colors[2] = COLOR_W'($urandom);
        phase_colors[3] = 8'h4E;
        phase_colors[4] = COLOR_W'($urandom);
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            write_text_color(phase_colors[phase]);
            no_idle = (phase == 2);
            if (phase == 3)
                holdoff_req = 1'b1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                random_group(count);
                sent += count;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("[text_mode_terminal_writer] OK");
        else
            $display("[text_mode_terminal_writer] ERROR");
        $finish;
    end

endmodule
